// File: rtl/chs_pkg.sv
// chs_pkg: sizes, command codes, state type and the bucket hash step for the chained hash set
// no dependencies; imported by chained_hash_set, chs_props, chs_checker and tb
`timescale 1ns / 1ps

package chs_pkg;

	localparam int BUCKETS = 7;
	localparam int SLOTS   = 8;
	localparam int ENTRIES = BUCKETS * SLOTS;

	localparam int KEY_W   = 31;
	localparam int CMD_W   = 2;
	localparam int CNT_W   = 4;
	localparam int CNT_MAX = (1 << CNT_W) - 1;

	localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ISS_W   = $clog2(SLOTS + 1);
	localparam int ENT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// key + 1 never wraps, so the hashed value is one bit wider than the key
	localparam int HASH_W  = KEY_W + 1;
	localparam int DIG_W   = 8;
	localparam int NUM_DIG = (HASH_W + DIG_W - 1) / DIG_W;
	localparam int HPAD_W  = NUM_DIG * DIG_W;
	localparam int DCNT_W  = (NUM_DIG > 1) ? $clog2(NUM_DIG) : 1;
	localparam int MOD_W   = BKT_W + DIG_W;

	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 8;

	localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH,
		ST_SCAN,
		ST_INSERT,
		ST_RESP
	} state_t;

	// one radix-256 step of the remainder: (r * 256 + d) mod BUCKETS by restoring subtraction
	function automatic logic [BKT_W-1:0] mod_step(logic [BKT_W-1:0] r, logic [DIG_W-1:0] d);
		logic [MOD_W-1:0] v;
		logic [MOD_W-1:0] b;
		v = {r, d};
		for (int k = DIG_W - 1; k >= 0; k--) begin
			b = MOD_W'(BUCKETS) << k;
			if (v >= b) begin
				v = v - b;
			end
		end
		return v[BKT_W-1:0];
	endfunction

endpackage

// File: rtl/chained_hash_set.sv
// chained_hash_set: top level, sequencer, key store memory and slot valid flags
// depends on chs_pkg
`timescale 1ns / 1ps

// Hash set of 31-bit keys, 7 buckets of 8 slots, bucket = (key + 1) mod 7. One command per
// input beat (tuser: 0 find, 1 insert, 2 remove); one result beat per command. The block takes
// one command at a time: s_tready is high only while it waits for a command. The bucket
// remainder is worked out by a shared radix-256 reduction step, one byte of key + 1 a cycle.
// Find and remove then read the bucket's 8 entries through the key store's registered read
// port, one per cycle, each compared in the cycle after its read; insert takes the lowest free
// slot in state ST_INSERT. A result waits while an earlier result has not been taken. Slot valid
// flags are cleared by reset, so the block is usable as soon as reset is released.
module chained_hash_set (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [chs_pkg::S_DATA_W-1:0]   s_tdata,   // [30:0] key, [31] zero
	input  logic [chs_pkg::CMD_W-1:0]      s_tuser,   // [1:0] cmd
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [chs_pkg::M_DATA_W-1:0]   m_tdata    // [0] found, [1] status,
	                                                  // [5:2] removed_count, [7:6] zero
);
	import chs_pkg::*;

	state_t state_q, state_nxt;

	logic [CMD_W-1:0]  cmd_q;
	logic [KEY_W-1:0]  key_q;
	logic [HPAD_W-1:0] hval_q;
	logic [BKT_W-1:0]  rem_q;
	logic [BKT_W-1:0]  rem_nxt;
	logic [DCNT_W-1:0] dig_cnt_q;
	logic [ENT_W-1:0]  base_q;
	logic [ISS_W-1:0]  iss_cnt_q;
	logic [ENT_W-1:0]  rd_addr;
	logic [KEY_W-1:0]  rd_key_q;
	logic              cmp_v_s1;
	logic [ENT_W-1:0]  cmp_idx_s1;
	logic              hit;

	logic              found_q;
	logic              status_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              m_tvalid_q;
	logic              out_found_q;
	logic              out_status_q;
	logic [CNT_W-1:0]  out_cnt_q;

	logic [ENTRIES-1:0] valid_q;
	logic [KEY_W-1:0]   key_store [ENTRIES];

	logic [SLOTS-1:0]  bkt_valid;
	logic              free_found;
	logic [SLOT_W-1:0] free_slot;
	logic [ENT_W-1:0]  wr_addr;

	logic accept;
	logic hash_en;
	logic last_dig;
	logic issue_en;
	logic scan_done;
	logic ins_en;
	logic resp_load;

	assign accept    = s_tvalid && s_tready;
	assign last_dig  = (dig_cnt_q == DCNT_W'(NUM_DIG - 1));
	// last compare happens in the cycle after the final read is issued
	assign scan_done = (iss_cnt_q == ISS_W'(SLOTS));
	assign rem_nxt   = mod_step(rem_q, hval_q[HPAD_W-1 -: DIG_W]);
	assign rd_addr   = base_q + ENT_W'(iss_cnt_q[SLOT_W-1:0]);
	assign hit       = cmp_v_s1 && valid_q[cmp_idx_s1] && (rd_key_q == key_q);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nxt = ST_HASH;
			end
			ST_HASH: begin
				if (last_dig) begin
					case (cmd_q) inside
						CMD_FIND, CMD_REMOVE: state_nxt = ST_SCAN;
						CMD_INSERT:           state_nxt = ST_INSERT;
						default:              state_nxt = ST_RESP;
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_done) state_nxt = ST_RESP;
			end
			ST_INSERT: begin
				state_nxt = ST_RESP;
			end
			ST_RESP: begin
				if (!m_tvalid_q || m_tready) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		hash_en   = 1'b0;
		issue_en  = 1'b0;
		ins_en    = 1'b0;
		resp_load = 1'b0;
		unique case (state_q)
			ST_IDLE:   s_tready  = 1'b1;
			ST_HASH:   hash_en   = 1'b1;
			ST_SCAN:   issue_en  = (iss_cnt_q != ISS_W'(SLOTS));
			ST_INSERT: ins_en    = 1'b1;
			ST_RESP:   resp_load = !m_tvalid_q || m_tready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// lowest free slot of the bucket
	always_comb begin
		bkt_valid  = valid_q[base_q +: SLOTS];
		free_found = 1'b0;
		free_slot  = '0;
		for (int s = SLOTS - 1; s >= 0; s--) begin
			if (!bkt_valid[s]) begin
				free_found = 1'b1;
				free_slot  = SLOT_W'(s);
			end
		end
	end

	assign wr_addr = base_q + ENT_W'(free_slot);

	// command, hash and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_cnt_q <= '0;
			iss_cnt_q <= '0;
			cmp_v_s1  <= 1'b0;
		end else begin
			cmp_v_s1 <= issue_en;
			if (accept) begin
				dig_cnt_q <= '0;
				iss_cnt_q <= '0;
			end else begin
				if (hash_en) dig_cnt_q <= dig_cnt_q + DCNT_W'(1);
				if (issue_en) iss_cnt_q <= iss_cnt_q + ISS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= s_tuser;
			key_q    <= s_tdata[KEY_W-1:0];
			hval_q   <= HPAD_W'({1'b0, s_tdata[KEY_W-1:0]}) + HPAD_W'(1);
			rem_q    <= '0;
			found_q  <= 1'b0;
			status_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (hash_en) begin
				rem_q  <= rem_nxt;
				hval_q <= hval_q << DIG_W;
				if (last_dig) base_q <= ENT_W'(int'(rem_nxt) * SLOTS);
			end
			if (issue_en) cmp_idx_s1 <= rd_addr;
			if (hit) begin
				case (cmd_q)
					CMD_FIND: found_q <= 1'b1;
					CMD_REMOVE: begin
						if (cnt_q != CNT_W'(CNT_MAX)) cnt_q <= cnt_q + CNT_W'(1);
					end
					default: begin
					end
				endcase
			end
			if (ins_en) status_q <= !free_found;
		end
	end

	// slot valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ins_en && free_found) valid_q[wr_addr] <= 1'b1;
			if (hit && (cmd_q == CMD_REMOVE)) valid_q[cmp_idx_s1] <= 1'b0;
		end
	end

	// key store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ins_en && free_found) key_store[wr_addr] <= key_q;
	end

	always_ff @(posedge clk) begin
		if (issue_en) rd_key_q <= key_store[rd_addr];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			if (resp_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (resp_load) begin
			out_found_q  <= found_q;
			out_status_q <= status_q;
			out_cnt_q    <= cnt_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, out_cnt_q, out_status_q, out_found_q};

endmodule

// File: rtl/chs_checker.sv
// chs_props: port-level assertions for chained_hash_set, bound to the top level
// depends on chs_pkg and chained_hash_set
`timescale 1ns / 1ps

module chs_props (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [chs_pkg::S_DATA_W-1:0]   s_tdata,
	input logic [chs_pkg::CMD_W-1:0]      s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [chs_pkg::M_DATA_W-1:0]   m_tdata
);
	import chs_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// one command at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command taken while busy");

	// a new result only appears while the block is busy with a command
	a_result_from_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result without a command");

	// at most one result field is meaningful, count bounded by the chain length
	a_fields_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]) && (m_tdata[7:6] == 2'b00)
			&& (m_tdata[5:2] <= CNT_W'(SLOTS))
			&& ((m_tdata[5:2] == '0) || (!m_tdata[0] && !m_tdata[1])))
		else $error("inconsistent result fields");

endmodule

bind chained_hash_set chs_props u_chs_props (.*);

// File: bench/chs_checker.sv
// chs_checker: watches both streams of the chained hash set, predicts each answer and compares
// depends on chs_pkg; instantiated by tb beside the block
`timescale 1ns / 1ps

module chs_checker
	import chs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // [30:0] key, [31] zero
	input  logic [CMD_W-1:0]    s_tuser,   // [1:0] cmd
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [M_DATA_W-1:0] m_tdata,   // [0] found, [1] status, [5:2] removed_count
	output int                  fails,
	output int                  pending,
	output int                  hits,
	output int                  refusals,
	output int                  multi_removes
);

	typedef struct packed {
		logic             found;
		logic             status;
		logic [CNT_W-1:0] removed;
	} set_answer_t;

	logic [KEY_W-1:0] stored_key [ENTRIES];
	logic             slot_used  [ENTRIES];
	set_answer_t      answer_q   [$];
	int               result_idx = 0;

	initial begin
		fails         = 0;
		pending       = 0;
		hits          = 0;
		refusals      = 0;
		multi_removes = 0;
	end

	task automatic report(input string msg);
		$display("chs_checker: %s", msg);
		fails++;
	endtask

	// first entry of the key's bucket; key + 1 is taken one bit wider so it never wraps
	function automatic int bucket_base(input logic [KEY_W-1:0] k);
		logic [HASH_W-1:0] h;
		h = HASH_W'(k) + HASH_W'(1);
		return int'(h % HASH_W'(BUCKETS)) * SLOTS;
	endfunction

	function automatic set_answer_t apply_cmd(input logic [CMD_W-1:0] c,
	                                          input logic [KEY_W-1:0] k);
		set_answer_t a;
		int          base;
		int          n;
		a    = '0;
		n    = 0;
		base = bucket_base(k);
		case (c)
		CMD_FIND: begin
			for (int s = 0; s < SLOTS; s++)
				if (slot_used[base+s] && stored_key[base+s] == k)
					a.found = 1'b1;
		end
		CMD_INSERT: begin
			// lowest free slot wins; refused when none is free
			a.status = 1'b1;
			for (int s = 0; s < SLOTS; s++) begin
				if (a.status && !slot_used[base+s]) begin
					slot_used[base+s]  = 1'b1;
					stored_key[base+s] = k;
					a.status           = 1'b0;
				end
			end
		end
		CMD_REMOVE: begin
			for (int s = 0; s < SLOTS; s++) begin
				if (slot_used[base+s] && stored_key[base+s] == k) begin
					slot_used[base+s] = 1'b0;
					n++;
				end
			end
			a.removed = (n > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(n);
		end
		default: begin
		end
		endcase
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		set_answer_t want;
		set_answer_t fresh;
		if (!arst_n) begin
			for (int e = 0; e < ENTRIES; e++)
				slot_used[e] = 1'b0;
			answer_q.delete();
			pending <= 0;
		end else begin
			// older answer leaves before a new command joins
			if (m_tvalid && m_tready) begin
				if (answer_q.size() == 0) begin
					report($sformatf("result %0d arrived with nothing expected", result_idx));
				end else begin
					want = answer_q.pop_front();
					if (m_tdata[0] !== want.found)
						report($sformatf("result %0d found: expected %0d got %0b",
						                 result_idx, want.found, m_tdata[0]));
					if (m_tdata[1] !== want.status)
						report($sformatf("result %0d status: expected %0d got %0b",
						                 result_idx, want.status, m_tdata[1]));
					if (m_tdata[2 +: CNT_W] !== want.removed)
						report($sformatf("result %0d removed_count: expected %0d got %0d",
						                 result_idx, want.removed, m_tdata[2 +: CNT_W]));
				end
				result_idx++;
			end
			if (s_tvalid && s_tready) begin
				fresh = apply_cmd(s_tuser, s_tdata[KEY_W-1:0]);
				answer_q.insert(answer_q.size(), fresh);
				if (fresh.found)
					hits++;
				if (fresh.status)
					refusals++;
				if (fresh.removed > 1)
					multi_removes++;
			end
			pending <= answer_q.size();
		end
	end

endmodule

// File: bench/tb.sv
// tb: stimulus, ready/valid pacing and verdict for the chained hash set
// depends on chs_pkg, chained_hash_set and chs_checker
`timescale 1ns / 1ps

module tb;
	import chs_pkg::*;

	localparam int RESET_CYCLES = 9;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE       = 30;
	localparam int POOL_N       = 16;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [KEY_W-1:0] KEY_TOP    = {KEY_W{1'b1}};

	logic                clk;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic [CMD_W-1:0]    s_tuser  = CMD_FIND;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	int fails, pending, hits, refusals, multi_removes;

	bit rx_steady = 1'b0;
	int hold_seq  = 0;
	int hold_seen = 0;
	int hold_left = 0;
	bit tx_gaps   = 1'b1;
	int cycle_cnt = 0;
	int n_find = 0, n_insert = 0, n_remove = 0, n_unused = 0;

	logic [KEY_W-1:0] key_pool [POOL_N];

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	chained_hash_set dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	chs_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.fails         (fails),
		.pending       (pending),
		.hits          (hits),
		.refusals      (refusals),
		.multi_removes (multi_removes)
	);

	// result side: random stalls, a steady stretch, and a long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= rx_steady || ($urandom_range(99) >= 19);
		end
	end

	task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k);
		if (tx_gaps && $urandom_range(99) < 19) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < 40);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_DATA_W'(k);
		s_tuser  <= c;
		do
			@(posedge clk);
		while (!s_tready);
		case (c)
		CMD_FIND:   n_find++;
		CMD_INSERT: n_insert++;
		CMD_REMOVE: n_remove++;
		default:    n_unused++;
		endcase
	endtask

	// sender stops and waits for every outstanding answer
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_random(input int n);
		int               r;
		logic [CMD_W-1:0] c;
		logic [KEY_W-1:0] k;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 40)
				c = CMD_INSERT;
			else if (r < 70)
				c = CMD_FIND;
			else if (r < 95)
				c = CMD_REMOVE;
			else
				c = CMD_UNUSED;
			// mostly a small pool so chains fill, hit and empty again
			if ($urandom_range(99) < 75)
				k = key_pool[$urandom_range(POOL_N-1)];
			else
				k = KEY_W'($urandom);
			send_cmd(c, k);
		end
	endtask

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb NOT OK");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty set, extremes of the key, unused code
		send_cmd(CMD_FIND, '0);
		send_cmd(CMD_INSERT, '0);
		send_cmd(CMD_FIND, '0);
		send_cmd(CMD_INSERT, KEY_TOP - 1);
		send_cmd(CMD_INSERT, KEY_TOP);
		send_cmd(CMD_FIND, KEY_TOP - 1);
		send_cmd(CMD_FIND, KEY_TOP);
		send_cmd(CMD_UNUSED, '0);
		send_cmd(CMD_FIND, '0);
		send_cmd(CMD_REMOVE, '0);
		send_cmd(CMD_FIND, '0);
		// keys 2, 9, 16, 23, 30 share one bucket: fill it with duplicates, then overflow
		repeat (5) send_cmd(CMD_INSERT, KEY_W'(2));
		send_cmd(CMD_INSERT, KEY_W'(9));
		send_cmd(CMD_INSERT, KEY_W'(16));
		send_cmd(CMD_INSERT, KEY_W'(23));
		send_cmd(CMD_INSERT, KEY_W'(30));
		send_cmd(CMD_REMOVE, KEY_W'(2));
		send_cmd(CMD_FIND, KEY_W'(9));
		send_cmd(CMD_REMOVE, KEY_W'(30));
		send_cmd(CMD_FIND, KEY_W'(2));

		key_pool[0] = '0;
		key_pool[1] = KEY_TOP - 1;
		key_pool[2] = KEY_TOP;
		for (int i = 3; i < POOL_N; i++)
			key_pool[i] = (i % 2) ? KEY_W'($urandom_range(60)) : KEY_W'($urandom);

		run_random(150);
		drain_results();

		// no idling on either side
		tx_gaps = 1'b0;
		rx_steady <= 1'b1;
		run_random(100);

		// long hold-off on the result side while commands keep coming
		rx_steady <= 1'b0;
		hold_seq  <= hold_seq + 1;
		run_random(12);

		tx_gaps = 1'b1;
		run_random(238);
		drain_results();

		$display("covered %0d commands: %0d finds, %0d inserts, %0d removes, %0d unused codes",
		         n_find + n_insert + n_remove + n_unused, n_find, n_insert, n_remove, n_unused);
		$display("find hits %0d, refused inserts %0d, removes of several keys %0d",
		         hits, refusals, multi_removes);
		if (fails == 0 && pending == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
